/* rtl/miq_pkg.sv */
// Shared types and constants for the MPEG-2 inverse quantizer.
// Used by miq_dequant, the top level and the testbench; depends on nothing else.
package miq_pkg;

    localparam int BLOCK_COEFFS_DEF   = 64;
    localparam int NUM_COMPONENTS_DEF = 3;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 6;
    localparam int COMP_W   = 2;
    localparam int SCALE_W  = 7;
    localparam int PREC_W   = 2;
    localparam int WEIGHT_W = 8;
    localparam int OUT_W    = 12;
    localparam int SUM_W    = 32;
    localparam int TERM_W   = 17;
    localparam int PROD1_W  = TERM_W + WEIGHT_W;
    localparam int PROD2_W  = 32;
    localparam int FRAC_SH  = 5;
    localparam int DC_BASE_SH = 3;

    localparam logic [ACTION_W-1:0] ACT_COEF = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic ld_mul1;
        logic ld_mul2;
    } dp_ctrl_t;

endpackage

/* rtl/miq_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; width and depth come from parameters.
module miq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/miq_dequant.sv */
// Two-stage multiply and clip for non-DC coefficients.
// Depends on miq_pkg for widths and the stage control struct.
module miq_dequant (
    input  logic                                aclk,
    input  miq_pkg::dp_ctrl_t                   ctrl,
    input  logic signed [miq_pkg::VALUE_W-1:0]  value,
    input  logic                                intra,
    input  logic [miq_pkg::WEIGHT_W-1:0]        weight,
    input  logic [miq_pkg::SCALE_W-1:0]         scale,
    output logic signed [miq_pkg::OUT_W-1:0]    coef_value
);

    localparam int SH_W = miq_pkg::PROD2_W - miq_pkg::FRAC_SH;

    logic signed [miq_pkg::TERM_W-1:0] value_x;
    logic [miq_pkg::TERM_W-1:0]        mag;
    logic [miq_pkg::TERM_W-1:0]        term;
    logic [miq_pkg::PROD1_W-1:0]       prod1_reg;
    logic [miq_pkg::PROD2_W-1:0]       prod2_reg;
    logic [SH_W-1:0]                   shifted;

    // The magnitude never exceeds 2^15, so doubling it fits in 17 bits.
    assign value_x = {value[miq_pkg::VALUE_W-1], value};
    assign mag     = value_x[miq_pkg::TERM_W-1] ? miq_pkg::TERM_W'(-value_x)
                                                : miq_pkg::TERM_W'(value_x);
    assign term    = {mag[miq_pkg::TERM_W-2:0], ~intra};

    always_ff @(posedge aclk) begin
        if (ctrl.ld_mul1) begin
            prod1_reg <= miq_pkg::PROD1_W'(term) * miq_pkg::PROD1_W'(weight);
        end
        if (ctrl.ld_mul2) begin
            prod2_reg <= miq_pkg::PROD2_W'(prod1_reg) * miq_pkg::PROD2_W'(scale);
        end
    end

    assign shifted = prod2_reg[miq_pkg::PROD2_W-1:miq_pkg::FRAC_SH];

    always_comb begin
        if (value == '0) begin
            coef_value = '0;
        end else if (value[miq_pkg::VALUE_W-1]) begin
            if (shifted > SH_W'(2048)) begin
                coef_value = 12'sh800;
            end else begin
                coef_value = miq_pkg::OUT_W'(-shifted[miq_pkg::OUT_W-1:0]);
            end
        end else begin
            if (shifted > SH_W'(2047)) begin
                coef_value = 12'sh7FF;
            end else begin
                coef_value = shifted[miq_pkg::OUT_W-1:0];
            end
        end
    end

endmodule

/* rtl/mpeg2_inverse_quantizer_top.sv */
// Top level of the MPEG-2 inverse quantizer: sequencer, DC predictors, block sum.
// Depends on miq_pkg, miq_ram (weight tables) and miq_dequant (multiply and clip).
//
//  Chan   Dir  Handshake        Payload
//  s_*    in   s_valid/s_ready  action value position intra component quant_scale first last
//  m_*    out  m_valid/m_ready  out_position out_value out_last mismatch_word
//  cfg_*  in   cfg_wr_en        cfg_wr_data: dc_precision (2 bits)
//
// A coefficient item has its weight read at the accepting edge; s_ready then stays low
// through ST_READ and ST_MUL (two multiply stages) and ST_FIN (the clip into the output
// register), after which its result is valid. Load and set items leave s_ready high.
// A result waiting in the output register stalls the next coefficient item in its clip
// step, and s_ready stays low until the waiting result is taken.
// Sync active-low reset clears only state, m_valid, predictors, block sum and dc_precision.
module mpeg2_inverse_quantizer_top #(
    parameter int BLOCK_COEFFS   = miq_pkg::BLOCK_COEFFS_DEF,
    parameter int NUM_COMPONENTS = miq_pkg::NUM_COMPONENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [miq_pkg::PREC_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [miq_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [miq_pkg::VALUE_W-1:0]  s_value,
    input  logic [miq_pkg::POS_W-1:0]           s_position,
    input  logic                                s_intra,
    input  logic [miq_pkg::COMP_W-1:0]          s_component,
    input  logic [miq_pkg::SCALE_W-1:0]         s_quant_scale,
    input  logic                                s_first_in_block,
    input  logic                                s_last_in_block,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [miq_pkg::POS_W-1:0]           m_out_position,
    output logic signed [miq_pkg::OUT_W-1:0]    m_out_value,
    output logic                                m_out_last,
    output logic [miq_pkg::SUM_W-1:0]           m_mismatch_word
);

    localparam int TABLE_DEPTH = 2 * BLOCK_COEFFS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POSX_W      = miq_pkg::POS_W + 1;
    localparam int DCX_W       = miq_pkg::VALUE_W + miq_pkg::DC_BASE_SH;

    miq_pkg::state_t state_reg, state_next;

    // Fields of the coefficient item in flight.
    logic signed [miq_pkg::VALUE_W-1:0] value_reg;
    logic [miq_pkg::POS_W-1:0]          pos_reg;
    logic                               intra_reg;
    logic [miq_pkg::COMP_W-1:0]         comp_reg;
    logic [miq_pkg::SCALE_W-1:0]        scale_reg;
    logic                               first_reg;
    logic                               last_reg;
    logic                               dc_path_reg;
    logic signed [miq_pkg::OUT_W-1:0]   dc_res_reg;

    logic [miq_pkg::PREC_W-1:0]         dc_precision_reg;
    logic [miq_pkg::VALUE_W-1:0]        dc_pred_reg [NUM_COMPONENTS];
    logic [miq_pkg::SUM_W-1:0]          sum_reg, sum_next;

    logic                               m_valid_reg;
    logic [miq_pkg::POS_W-1:0]          m_pos_reg;
    logic signed [miq_pkg::OUT_W-1:0]   m_value_reg;
    logic                               m_last_reg;
    logic [miq_pkg::SUM_W-1:0]          m_mismatch_reg;

    logic                               accept;
    logic                               out_free;
    logic [ADDR_W-1:0]                  ram_addr;
    logic                               ram_we;
    logic [miq_pkg::WEIGHT_W-1:0]       ram_rdata;
    logic [miq_pkg::VALUE_W-1:0]        pred_sel;
    logic [miq_pkg::VALUE_W-1:0]        dc_sum;
    logic signed [DCX_W-1:0]            dc_scaled;
    logic signed [miq_pkg::OUT_W-1:0]   dc_clip;
    logic signed [miq_pkg::OUT_W-1:0]   coef_value;
    logic signed [miq_pkg::OUT_W-1:0]   result;
    miq_pkg::dp_ctrl_t                  dp_ctrl;

    assign s_ready  = (state_reg == miq_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Weight table address: position folded into the block size, with the intra
    // table placed in the upper half. At most three subtractions are needed.
    always_comb begin
        logic [POSX_W-1:0] pos_mod;
        pos_mod = {1'b0, s_position};
        for (int k = 0; k < 3; k++) begin
            if (pos_mod >= POSX_W'(BLOCK_COEFFS)) begin
                pos_mod = pos_mod - POSX_W'(BLOCK_COEFFS);
            end
        end
        if (s_intra) begin
            ram_addr = ADDR_W'(pos_mod) + ADDR_W'(BLOCK_COEFFS);
        end else begin
            ram_addr = ADDR_W'(pos_mod);
        end
    end

    assign ram_we = accept && (s_action == miq_pkg::ACT_LOAD);

    miq_ram #(
        .WIDTH (miq_pkg::WEIGHT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_value[miq_pkg::WEIGHT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer. The RAM is read every cycle at the address formed from the
    // input, so the weight for an accepted coefficient is ready in ST_READ.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            miq_pkg::ST_IDLE: begin
                if (accept && (s_action == miq_pkg::ACT_COEF)) begin
                    state_next = miq_pkg::ST_READ;
                end
            end
            miq_pkg::ST_READ: state_next = miq_pkg::ST_MUL;
            miq_pkg::ST_MUL:  state_next = miq_pkg::ST_FIN;
            miq_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = miq_pkg::ST_IDLE;
                end
            end
            default: state_next = miq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= miq_pkg::ST_IDLE;
            dc_precision_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                dc_precision_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg   <= s_value;
            pos_reg     <= s_position;
            intra_reg   <= s_intra;
            comp_reg    <= s_component;
            scale_reg   <= s_quant_scale;
            first_reg   <= s_first_in_block;
            last_reg    <= s_last_in_block;
            dc_path_reg <= s_first_in_block && s_intra;
        end
        if (state_reg == miq_pkg::ST_READ) begin
            dc_res_reg <= dc_clip;
        end
    end

    // DC path: predictor plus differential wraps to 16 bits, then the scaled
    // value is clipped. A component without a predictor reads as zero.
    always_comb begin
        pred_sel = '0;
        for (int i = 0; i < NUM_COMPONENTS; i++) begin
            if (comp_reg == miq_pkg::COMP_W'(i)) begin
                pred_sel = dc_pred_reg[i];
            end
        end
    end

    assign dc_sum    = miq_pkg::VALUE_W'(value_reg) + pred_sel;
    assign dc_scaled = DCX_W'($signed(dc_sum)) <<<
                       (miq_pkg::PREC_W'(miq_pkg::DC_BASE_SH) - dc_precision_reg);

    always_comb begin
        if (dc_scaled > DCX_W'(2047)) begin
            dc_clip = 12'sh7FF;
        end else if (dc_scaled < -DCX_W'(2048)) begin
            dc_clip = 12'sh800;
        end else begin
            dc_clip = dc_scaled[miq_pkg::OUT_W-1:0];
        end
    end

    // Predictors: a set item writes one directly; an intra DC item writes back
    // the accumulated DC in its read step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COMPONENTS; i++) begin
                dc_pred_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_COMPONENTS; i++) begin
                if (accept && (s_action == miq_pkg::ACT_SET) &&
                    (s_component == miq_pkg::COMP_W'(i))) begin
                    dc_pred_reg[i] <= s_value;
                end else if ((state_reg == miq_pkg::ST_READ) && dc_path_reg &&
                             (comp_reg == miq_pkg::COMP_W'(i))) begin
                    dc_pred_reg[i] <= dc_sum;
                end
            end
        end
    end

    assign dp_ctrl.ld_mul1 = (state_reg == miq_pkg::ST_READ);
    assign dp_ctrl.ld_mul2 = (state_reg == miq_pkg::ST_MUL);

    miq_dequant u_dequant (
        .aclk       (aclk),
        .ctrl       (dp_ctrl),
        .value      (value_reg),
        .intra      (intra_reg),
        .weight     (ram_rdata),
        .scale      (scale_reg),
        .coef_value (coef_value)
    );

    assign result   = dc_path_reg ? dc_res_reg : coef_value;
    assign sum_next = (first_reg ? '0 : sum_reg) +
                      {{(miq_pkg::SUM_W - miq_pkg::OUT_W){result[miq_pkg::OUT_W-1]}}, result};

    // Block sum and output register are updated together when the result is
    // handed to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == miq_pkg::ST_FIN) && out_free) begin
                sum_reg     <= sum_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == miq_pkg::ST_FIN) && out_free) begin
            m_pos_reg      <= pos_reg;
            m_value_reg    <= result;
            m_last_reg     <= last_reg;
            m_mismatch_reg <= sum_next ^ miq_pkg::SUM_W'(1);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_position  = m_pos_reg;
    assign m_out_value     = m_value_reg;
    assign m_out_last      = m_last_reg;
    assign m_mismatch_word = m_mismatch_reg;

    // The read step only follows an accepted coefficient item.
    a_read_after_coef: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == miq_pkg::ST_READ) |->
        $past(s_valid && s_ready && (s_action == miq_pkg::ACT_COEF)))
        else $error("read step without an accepted coefficient item");

    // The multiply pipeline never stalls between its two stages.
    a_mul_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == miq_pkg::ST_MUL) |=> (state_reg == miq_pkg::ST_FIN))
        else $error("multiply step not followed by the final step");

    // A finished item with a free output register is delivered and releases input.
    a_fin_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == miq_pkg::ST_FIN) && (!m_valid_reg || m_ready)) |=>
        (m_valid_reg && (state_reg == miq_pkg::ST_IDLE)))
        else $error("finished item not delivered");

    // The block sum changes only when a result is produced.
    a_sum_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != miq_pkg::ST_FIN) |=> $stable(sum_reg))
        else $error("block sum changed outside the final step");

endmodule

/* tb/tb_mpeg2_inverse_quantizer_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mpeg2_inverse_quantizer_top: directed and random item streams
// checked against a behavioral predictor. Depends on miq_pkg and the block's RTL only.
module tb_mpeg2_inverse_quantizer_top;
    import miq_pkg::*;

    // Ignored action code; the package only names the three live ones.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_PRED = NUM_COMPONENTS_DEF;
    localparam int PHASE_ITEMS = 600;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;

    // One input item, field by field, as the block sees it.
    typedef struct packed {
        bit [ACTION_W-1:0]      action;
        bit signed [VALUE_W-1:0] value;
        bit [POS_W-1:0]         position;
        bit                     intra;
        bit [COMP_W-1:0]        component;
        bit [SCALE_W-1:0]       scale;
        bit                     first;
        bit                     last;
    } coef_item_t;

    // One result item. Four-state so that an X on the outputs shows up as a mismatch.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [OUT_W-1:0] value;
        logic             last;
        logic [SUM_W-1:0] mismatch;
    } coef_result_t;

    // The scoreboard keeps its own copy of the weight tables, DC predictors, block sum and
    // DC precision. Accepted load, set and coefficient items update that copy; coefficient
    // items push the dequantized value they must produce, and results are compared in order.
    class dequant_scoreboard;
        bit [WEIGHT_W-1:0] weights [0:2*BLOCK_COEFFS_DEF-1];
        bit [VALUE_W-1:0]  dc_pred [0:NUM_PRED-1];
        bit [SUM_W-1:0]    block_sum;
        bit [PREC_W-1:0]   dc_prec;
        coef_result_t      expected_coefs [$];
        int                fail_count;

        function void set_precision(bit [PREC_W-1:0] prec);
            dc_prec = prec;
        endfunction

        function int pending();
            return expected_coefs.size();
        endfunction

        function void take_item(coef_item_t it);
            bit [6:0]                widx;
            bit [VALUE_W-1:0]        pred;
            bit signed [VALUE_W-1:0] dc;
            longint                  full;
            longint                  mag;
            longint                  prod;
            int                      res;
            int                      sh;
            coef_result_t            r;
            widx = {it.intra, it.position};
            case (it.action)
                ACT_LOAD: begin
                    weights[widx] = it.value[WEIGHT_W-1:0];
                end
                ACT_SET: begin
                    if (it.component < NUM_PRED) dc_pred[it.component] = it.value;
                end
                ACT_COEF: begin
                    if (it.first) block_sum = '0;
                    if (it.first && it.intra) begin
                        // DC differential: 16-bit wrap on the predictor sum, full-width
                        // scaling, then the 12-bit clip below.
                        pred = (it.component < NUM_PRED) ? dc_pred[it.component] : '0;
                        dc = it.value + pred;
                        if (it.component < NUM_PRED) dc_pred[it.component] = dc;
                        sh = DC_BASE_SH - int'(dc_prec);
                        full = longint'(dc) <<< sh;
                    end else if (it.value == 0) begin
                        full = 0;
                    end else begin
                        mag = (it.value < 0) ? -longint'(it.value) : longint'(it.value);
                        prod = ((mag << 1) + (it.intra ? 0 : 1)) * longint'(weights[widx])
                               * longint'(it.scale);
                        prod = prod >> FRAC_SH;
                        full = (it.value < 0) ? -prod : prod;
                    end
                    if (full > 2047) res = 2047;
                    else if (full < -2048) res = -2048;
                    else res = int'(full);
                    block_sum = block_sum + res;
                    r.position = it.position;
                    r.value = res[OUT_W-1:0];
                    r.last = it.last;
                    r.mismatch = block_sum ^ 32'd1;
                    expected_coefs.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_coef(coef_result_t got);
            coef_result_t want;
            if (expected_coefs.size() == 0) begin
                $error("result with nothing expected: position %0d value %0d",
                       got.position, $signed(got.value));
                fail_count++;
                return;
            end
            want = expected_coefs.pop_front();
            if (got.position !== want.position) begin
                $error("out_position: expected %0d, actual %0d", want.position, got.position);
                fail_count++;
            end
            if (got.value !== want.value) begin
                $error("out_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(got.value));
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("out_last: expected %0d, actual %0d", want.last, got.last);
                fail_count++;
            end
            if (got.mismatch !== want.mismatch) begin
                $error("mismatch_word: expected %h, actual %h", want.mismatch, got.mismatch);
                fail_count++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [PREC_W-1:0]     cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    coef_item_t            s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [POS_W-1:0]      m_out_position;
    logic signed [OUT_W-1:0] m_out_value;
    logic                  m_out_last;
    logic [SUM_W-1:0]      m_mismatch_word;

    dequant_scoreboard sb = new();

    // Idle percentages for the sender and the receiver; the main sequence changes them
    // from phase to phase.
    int send_idle_pct = 33;
    int recv_idle_pct = 64;
    int items_sent = 0;
    int cycle_count = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mpeg2_inverse_quantizer_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_item.action),
        .s_value          (s_item.value),
        .s_position       (s_item.position),
        .s_intra          (s_item.intra),
        .s_component      (s_item.component),
        .s_quant_scale    (s_item.scale),
        .s_first_in_block (s_item.first),
        .s_last_in_block  (s_item.last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_position   (m_out_position),
        .m_out_value      (m_out_value),
        .m_out_last       (m_out_last),
        .m_mismatch_word  (m_mismatch_word)
    );

    // Both handshakes are sampled right after the rising edge, which still shows the values
    // from before the edge. Results are checked before the new item is noted, although an
    // item accepted at this edge can never have its result at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_coef(coef_result_t'{m_out_position, m_out_value, m_out_last,
                                             m_mismatch_word});
            if (s_valid && s_ready) sb.take_item(s_item);
        end
    end

    // Receiver. A hold request blocks m_ready for a long stretch so that the block's
    // output register and pipeline fill up and s_ready has to drop.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic coef_item_t make_item(bit [ACTION_W-1:0] action, bit [VALUE_W-1:0] value,
                                             bit [POS_W-1:0] position, bit intra,
                                             bit [COMP_W-1:0] component,
                                             bit [SCALE_W-1:0] scale, bit first, bit last);
        coef_item_t it;
        it.action = action;
        it.value = value;
        it.position = position;
        it.intra = intra;
        it.component = component;
        it.scale = scale;
        it.first = first;
        it.last = last;
        return it;
    endfunction

    // Quantizer scale with its two extremes showing up often.
    function automatic bit [SCALE_W-1:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return SCALE_W'(0);
            1: return SCALE_W'(112);
            default: return SCALE_W'($urandom_range(1, 112));
        endcase
    endfunction

    // Coefficient or DC differential: mostly small, sometimes zero, full range or extreme.
    function automatic bit [VALUE_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return VALUE_W'($urandom);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return VALUE_W'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Called at a rising edge. The valid line may idle first; once raised it is held with
    // its payload until the item is taken, and is left high for the next call to decide.
    task automatic send_item(input coef_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.action != ACT_UNUSED) items_sent++;
    endtask

    // Waits until every result has come back, then lets the pipeline run empty, since
    // load, set and ignored items leave nothing in the queue to wait on.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_precision(input bit [PREC_W-1:0] prec);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= prec;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_precision(prec);
    endtask

    // Every entry of both tables is written before any coefficient can read it. The upper
    // byte of the value is junk that the block must drop. A few entries are pinned to the
    // weight extremes for the directed items.
    task automatic fill_tables();
        coef_item_t it;
        for (int idx = 0; idx < 2 * BLOCK_COEFFS_DEF; idx++) begin
            it = make_item(ACT_LOAD, VALUE_W'($urandom), idx[5:0], idx[6],
                           COMP_W'($urandom_range(0, 3)), rand_scale(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (idx == 63 || idx == 64 + 63 || idx == 64 + 1) it.value[7:0] = 8'hFF;
            if (idx == 5) it.value[7:0] = 8'h00;
            send_item(it);
        end
    endtask

    task automatic run_directed();
        // The DC sum wraps past the top of 16 bits and clips low.
        send_item(make_item(ACT_SET, 16'h7FFF, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_COEF, 16'h0001, 0, 1, 0, 112, 1, 0));
        // Largest magnitudes at full scale and weight clip high and low.
        send_item(make_item(ACT_COEF, 16'h7FFF, 63, 1, 0, 112, 0, 0));
        send_item(make_item(ACT_COEF, 16'h8000, 1, 1, 0, 112, 0, 1));
        // A zero coefficient in a non-intra block stays zero despite the rounding term.
        send_item(make_item(ACT_COEF, 16'h0000, 0, 0, 1, 50, 1, 0));
        // Zero weight, then weight 255 with scale one, then scale zero.
        send_item(make_item(ACT_COEF, 16'h0007, 5, 0, 1, 50, 0, 0));
        send_item(make_item(ACT_COEF, 16'hFFFF, 63, 0, 1, 1, 0, 0));
        send_item(make_item(ACT_COEF, 16'h0064, 2, 0, 1, 0, 0, 1));
        // Component out of range: the set is dropped, the DC item uses a zero predictor.
        send_item(make_item(ACT_SET, 16'h1234, 0, 0, 3, 0, 0, 0));
        send_item(make_item(ACT_COEF, 16'h0005, 0, 1, 3, 10, 1, 1));
        // Predictors at -1 and at the most negative value; the differential added to -1 wraps.
        send_item(make_item(ACT_SET, 16'hFFFF, 0, 0, 1, 0, 0, 0));
        send_item(make_item(ACT_SET, 16'h8000, 0, 0, 2, 0, 0, 0));
        send_item(make_item(ACT_COEF, 16'h8000, 0, 1, 1, 20, 1, 0));
        send_item(make_item(ACT_COEF, 16'h0064, 0, 1, 2, 20, 1, 0));
        // The unused action code with every field at its top is ignored.
        send_item(make_item(ACT_UNUSED, 16'hFFFF, 63, 1, 3, 112, 1, 1));
        // A load with upper bits set, then positive and negative coefficients that use it.
        send_item(make_item(ACT_LOAD, 16'hFF80, 10, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_COEF, 16'h0003, 10, 0, 0, 9, 1, 0));
        send_item(make_item(ACT_COEF, 16'hFFFD, 10, 0, 0, 9, 0, 1));
        // A one-item intra block with a zero differential, then a stray intra AC item.
        send_item(make_item(ACT_COEF, 16'h0000, 0, 1, 0, 5, 1, 1));
        send_item(make_item(ACT_COEF, 16'h0001, 3, 1, 0, 1, 0, 1));
    endtask

    // Anything at all: loads, sets, ignored codes and lone coefficients with random flags.
    task automatic send_noise();
        coef_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it = make_item(ACT_COEF, VALUE_W'($urandom), POS_W'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), COMP_W'($urandom_range(0, 3)), rand_scale(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (pick < 35) it.action = ACT_LOAD;
        else if (pick < 60) it.action = ACT_SET;
        else if (pick < 75) it.action = ACT_UNUSED;
        send_item(it);
    endtask

    // A well-formed block: a first item (the DC differential when intra), rising positions
    // and a closing item. One block in ten gets its first or last flags disturbed.
    task automatic send_block();
        coef_item_t it;
        int len;
        int pos;
        int step;
        bit broken;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        it = make_item(ACT_COEF, 0, 0, 1'($urandom_range(0, 1)),
                       COMP_W'(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2)),
                       rand_scale(), 0, 0);
        pos = 0;
        for (int k = 0; k < len; k++) begin
            it.first = (k == 0);
            it.last = (k == len - 1);
            if (broken && $urandom_range(0, 3) == 0) it.first = ~it.first;
            if (broken && $urandom_range(0, 3) == 0) it.last = ~it.last;
            it.position = POS_W'(pos);
            it.value = rand_coef();
            send_item(it);
            if ($urandom_range(0, 29) == 0) send_noise();
            step = $urandom_range(1, 4);
            pos = (pos + step > 63) ? 63 : pos + step;
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 99) < 85) send_block();
            else send_noise();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks run at the highest DC precision, where the DC is not shifted.
        write_precision(3);
        fill_tables();
        run_directed();
        settle();

        // Random phases, each at its own precision and with its own idling pattern.
        write_precision(0);
        send_idle_pct = 33;
        recv_idle_pct = 64;
        run_random(PHASE_ITEMS);
        settle();

        write_precision(2);
        send_idle_pct = 64;
        recv_idle_pct = 33;
        run_random(PHASE_ITEMS);
        settle();

        // No idling on either side, with one long receiver hold-off at the start while
        // the sender keeps pushing items.
        write_precision(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);
        settle();

        if (sb.fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/miq_pkg.sv
rtl/miq_ram.sv
rtl/miq_dequant.sv
rtl/mpeg2_inverse_quantizer_top.sv
tb/tb_mpeg2_inverse_quantizer_top.sv
